// ===== hdl/dsftk_pkg.sv =====
// shared types, constants and register codes for the detection score filter
package dsftk_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 64;
   localparam int unsigned QUEUE_DEPTH      = 2;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 64;
   localparam int unsigned MAX_DET_W   = 7;

   localparam logic [15:0]           SCORE_THRESHOLD_RESET = 16'd16384;
   localparam logic                  CLASS_FILTER_EN_RESET = 1'b0;
   localparam logic [63:0]           CLASS_MASK_RESET      = 64'd0;
   localparam logic [MAX_DET_W-1:0]  MAX_DETECTIONS_RESET  = '0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCORE_THRESHOLD = 3'd0,
      CSR_CLASS_FILTER_EN = 3'd1,
      CSR_CLASS_MASK      = 3'd2,
      CSR_MAX_DETECTIONS  = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic [15:0]          score_threshold;
      logic                 class_filter_en;
      logic [63:0]          class_mask;
      logic [MAX_DET_W-1:0] max_detections;
   } csr_type;

   typedef struct packed {
      logic [15:0] score;
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] angle;
      logic [7:0]  label;
   } box_type;

   // classified proposal handed from the front end to the ranker
   typedef struct packed {
      logic    keep;
      logic    last;
      box_type box;
   } cand_type;

   typedef struct packed {
      box_type box;
      logic    final_flag;
      logic    no_det;
      logic    ovf;
   } result_type;

   typedef enum logic {
      RK_INSERT,
      RK_DRAIN
   } rank_state_type;

endpackage

// ===== hdl/dsftk_queue.sv =====
// small synchronous fifo used between the pipeline parts
module dsftk_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int unsigned AW  = $clog2(DEPTH);
   localparam int unsigned CNW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNW-1:0]   count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // depth is a power of two, pointers wrap on their own
   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(do_push);
      rd_ptr_in = rd_ptr_ff + AW'(do_pop);
      count_in  = count_ff + CNW'(do_push) - CNW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/dsftk_front.sv =====
// front end: score and class filtering of incoming proposals
module dsftk_front import dsftk_pkg::*; (
   input  csr_type            csr,
   input  logic               req_push,
   output logic               req_full,
   input  logic [15:0]        req_center_x,
   input  logic [15:0]        req_center_y,
   input  logic [15:0]        req_box_width,
   input  logic [15:0]        req_box_height,
   input  logic [15:0]        req_confidence,
   input  logic [7:0]         req_class_label,
   input  logic signed [15:0] req_rotation,
   input  logic               req_end_of_set,
   input  logic               cand_full,
   output logic               cand_push,
   output cand_type           cand
);

   logic score_ok;
   logic class_ok;
   logic keep;

   always_comb begin
      score_ok = (req_confidence >= csr.score_threshold);
      // labels above 63 never pass while filtering is on
      class_ok = !csr.class_filter_en ||
                 ((req_class_label[7:6] == 2'b00) && csr.class_mask[req_class_label[5:0]]);
      keep     = score_ok && class_ok;
   end

   always_comb begin
      cand.keep         = keep;
      cand.last         = req_end_of_set;
      cand.box.score    = req_confidence;
      cand.box.center_x = req_center_x;
      cand.box.center_y = req_center_y;
      cand.box.width    = req_box_width;
      cand.box.height   = req_box_height;
      cand.box.angle    = req_rotation;
      cand.box.label    = req_class_label;
   end

   // dropped proposals that do not close a set need no slot in the queue
   assign req_full  = cand_full;
   assign cand_push = req_push && !cand_full && (keep || req_end_of_set);

endmodule

// ===== hdl/dsftk_rank.sv =====
// back end: compare-and-shift ranking chain and best-first drain
module dsftk_rank import dsftk_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  csr_type    csr,
   input  cand_type   cand,
   input  logic       cand_empty,
   output logic       cand_pop,
   output result_type result,
   output logic       result_push,
   input  logic       result_full
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   rank_state_type state_ff, state_in;

   box_type       cell_ff [CAPACITY];
   box_type       cell_in [CAPACITY];
   logic [CW-1:0] kept_ff, kept_in;
   logic          ovf_seen_ff, ovf_seen_in;
   logic [CW-1:0] emit_left_ff, emit_left_in;
   logic          set_empty_ff, set_empty_in;
   logic          set_ovf_ff, set_ovf_in;

   logic [CAPACITY-1:0]  ge;
   logic                 store_full;
   logic                 take;
   logic                 do_insert;
   logic                 shift_up;
   logic                 last_result;
   logic [CW-1:0]        kept_next;
   logic                 ovf_next;
   logic [MAX_DET_W-1:0] kept_wide;
   logic [CW-1:0]        emit_count;

   assign store_full  = (kept_ff == CW'(CAPACITY));
   assign take        = (state_ff == RK_INSERT) && !cand_empty;
   assign do_insert   = take && cand.keep;
   assign last_result = set_empty_ff || (emit_left_ff == CW'(1));
   assign shift_up    = result_push && !set_empty_ff;

   always_comb begin
      kept_next = kept_ff + CW'(do_insert && !store_full);
      ovf_next  = ovf_seen_ff || (do_insert && store_full);
      kept_wide = MAX_DET_W'(kept_next);
      if ((csr.max_detections != '0) && (csr.max_detections < kept_wide)) begin
         emit_count = CW'(csr.max_detections);
      end else begin
         emit_count = kept_next;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         RK_INSERT: begin
            if (take && cand.last) begin
               state_in = RK_DRAIN;
            end
         end
         RK_DRAIN: begin
            if (result_push && last_result) begin
               state_in = RK_INSERT;
            end
         end
         default: state_in = RK_INSERT;
      endcase
   end

   // outputs
   always_comb begin
      cand_pop    = 1'b0;
      result_push = 1'b0;
      case (state_ff)
         RK_INSERT: cand_pop    = !cand_empty;
         RK_DRAIN:  result_push = !result_full;
         default: begin
            cand_pop    = 1'b0;
            result_push = 1'b0;
         end
      endcase
   end

   always_comb begin
      result.box        = set_empty_ff ? '0 : cell_ff[0];
      result.final_flag = last_result;
      result.no_det     = set_empty_ff;
      result.ovf        = set_ovf_ff;
   end

   always_comb begin
      kept_in      = kept_ff;
      ovf_seen_in  = ovf_seen_ff;
      emit_left_in = emit_left_ff;
      set_empty_in = set_empty_ff;
      set_ovf_in   = set_ovf_ff;
      if (take) begin
         kept_in     = kept_next;
         ovf_seen_in = ovf_next;
         if (cand.last) begin
            emit_left_in = emit_count;
            set_empty_in = (kept_next == '0);
            set_ovf_in   = ovf_next;
         end
      end
      if (result_push) begin
         emit_left_in = emit_left_ff - CW'(1);
         if (last_result) begin
            kept_in     = '0;
            ovf_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RK_INSERT;
         kept_ff      <= '0;
         ovf_seen_ff  <= 1'b0;
         emit_left_ff <= '0;
         set_empty_ff <= 1'b0;
         set_ovf_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         ovf_seen_ff  <= ovf_seen_in;
         emit_left_ff <= emit_left_in;
         set_empty_ff <= set_empty_in;
         set_ovf_ff   <= set_ovf_in;
      end
   end

   // one cell per rank; ge is a prefix since the chain stays sorted
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] CellIdx = CW'(i);
      logic    take_new;
      box_type prev_box;
      box_type up_box;

      assign ge[i] = (CellIdx < kept_ff) && (cell_ff[i].score >= cand.box.score);

      if (i == 0) begin : g_head
         assign take_new = 1'b1;
         assign prev_box = cand.box;
      end else begin : g_body
         assign take_new = ge[i-1];
         assign prev_box = cell_ff[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign up_box = cell_ff[i];
      end else begin : g_inner
         assign up_box = cell_ff[i+1];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         if (shift_up) begin
            cell_in[i] = up_box;
         end else if (do_insert && !ge[i]) begin
            cell_in[i] = take_new ? cand.box : prev_box;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

endmodule

// ===== hdl/detection_score_filter_top_k.sv =====
// top level of the detection score filter with top-k ranking
// Proposals enter through a push/full queue port and are filtered by score
// threshold and optional class mask; survivors go through a short queue into
// a CAPACITY-deep compare-and-shift chain that inserts one proposal per clock
// cycle, keeping descending score with ties in arrival order. The proposal
// marked end_of_set is ranked like the others and then starts a drain: the
// chain emits one result per cycle while the output queue has room, best
// first, trimmed to max_detections (one result with no_detections set when
// nothing survived). During the drain the chain accepts no proposal; req_full
// rises once the front queue of QUEUE_DEPTH entries is full. Results wait in
// a small output queue read with pop/empty. Configuration registers are
// written with csr_wr_en, csr_index and csr_wdata and must only change while
// no set is in flight.
module detection_score_filter_top_k import dsftk_pkg::*; #(
   parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_push,
   output logic                   req_full,
   input  logic [15:0]            req_center_x,
   input  logic [15:0]            req_center_y,
   input  logic [15:0]            req_box_width,
   input  logic [15:0]            req_box_height,
   input  logic [15:0]            req_confidence,
   input  logic [7:0]             req_class_label,
   input  logic signed [15:0]     req_rotation,
   input  logic                   req_end_of_set,

   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [15:0]            rsp_out_center_x,
   output logic [15:0]            rsp_out_center_y,
   output logic [15:0]            rsp_out_width,
   output logic [15:0]            rsp_out_height,
   output logic [15:0]            rsp_out_confidence,
   output logic [7:0]             rsp_out_label,
   output logic signed [15:0]     rsp_out_rotation,
   output logic                   rsp_final_result,
   output logic                   rsp_no_detections,
   output logic                   rsp_capacity_overflow,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned CAND_W   = $bits(cand_type);
   localparam int unsigned RESULT_W = $bits(result_type);

   csr_type    csr_ff, csr_in;
   cand_type   cand_push_data, cand_head;
   result_type result_push_data, result_head;
   logic       cand_push, cand_full, cand_pop, cand_empty;
   logic       result_push, result_full;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SCORE_THRESHOLD: csr_in.score_threshold = csr_wdata[15:0];
            CSR_CLASS_FILTER_EN: csr_in.class_filter_en = csr_wdata[0];
            CSR_CLASS_MASK:      csr_in.class_mask      = csr_wdata;
            CSR_MAX_DETECTIONS:  csr_in.max_detections  = csr_wdata[MAX_DET_W-1:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.score_threshold <= SCORE_THRESHOLD_RESET;
         csr_ff.class_filter_en <= CLASS_FILTER_EN_RESET;
         csr_ff.class_mask      <= CLASS_MASK_RESET;
         csr_ff.max_detections  <= MAX_DETECTIONS_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   dsftk_front u_front (
      .csr             (csr_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_box_width   (req_box_width),
      .req_box_height  (req_box_height),
      .req_confidence  (req_confidence),
      .req_class_label (req_class_label),
      .req_rotation    (req_rotation),
      .req_end_of_set  (req_end_of_set),
      .cand_full       (cand_full),
      .cand_push       (cand_push),
      .cand            (cand_push_data)
   );

   dsftk_queue #(
      .WIDTH (CAND_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cand_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cand_push),
      .push_data (cand_push_data),
      .full      (cand_full),
      .pop       (cand_pop),
      .pop_data  (cand_head),
      .empty     (cand_empty)
   );

   dsftk_rank #(
      .CAPACITY (CAPACITY)
   ) u_rank (
      .clock       (clock),
      .reset       (reset),
      .csr         (csr_ff),
      .cand        (cand_head),
      .cand_empty  (cand_empty),
      .cand_pop    (cand_pop),
      .result      (result_push_data),
      .result_push (result_push),
      .result_full (result_full)
   );

   dsftk_queue #(
      .WIDTH (RESULT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (result_push_data),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_head),
      .empty     (rsp_empty)
   );

   assign rsp_out_center_x      = result_head.box.center_x;
   assign rsp_out_center_y      = result_head.box.center_y;
   assign rsp_out_width         = result_head.box.width;
   assign rsp_out_height        = result_head.box.height;
   assign rsp_out_confidence    = result_head.box.score;
   assign rsp_out_label         = result_head.box.label;
   assign rsp_out_rotation      = result_head.box.angle;
   assign rsp_final_result      = result_head.final_flag;
   assign rsp_no_detections     = result_head.no_det;
   assign rsp_capacity_overflow = result_head.ovf;

endmodule

// ===== hdl/dsftk_checker.sv =====
// port-level checks for the detection score filter, bound to the top level
module dsftk_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_out_confidence,
   input logic [15:0] rsp_out_center_x,
   input logic        rsp_final_result,
   input logic        rsp_no_detections,
   input logic        rsp_capacity_overflow
);

   // nothing to read right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_confidence) &&
                                    $stable(rsp_final_result)))
      else $error("waiting result changed before pop");

   // an empty set gives a single zero result
   a_empty_set: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_no_detections) |->
         (rsp_final_result && rsp_out_confidence == 16'd0 && rsp_out_center_x == 16'd0))
      else $error("no-detection result malformed");

   // within a set scores do not rise
   a_ranked: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_final_result) ##1 !rsp_empty |->
         (rsp_out_confidence <= $past(rsp_out_confidence) && !rsp_no_detections))
      else $error("results out of score order");

   // overflow flag is the same on every result of a set
   a_ovf_steady: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_final_result) ##1 !rsp_empty |->
         (rsp_capacity_overflow == $past(rsp_capacity_overflow)))
      else $error("overflow flag changed within a set");

endmodule

bind detection_score_filter_top_k dsftk_checker u_dsftk_checker (.*);

// ===== sim/tb_detection_score_filter_top_k.sv =====
// testbench for the detection score filter with top-k ranking
module tb_detection_score_filter_top_k import dsftk_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = CAPACITY_DEFAULT;

   typedef struct packed {
      logic [15:0] cx;
      logic [15:0] cy;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] conf;
      logic [7:0]  label;
      logic [15:0] rot;
      logic        eos;
   } proposal_type;

   logic                   clock;
   logic                   reset;
   logic                   req_push;
   logic                   req_full;
   logic [15:0]            req_center_x;
   logic [15:0]            req_center_y;
   logic [15:0]            req_box_width;
   logic [15:0]            req_box_height;
   logic [15:0]            req_confidence;
   logic [7:0]             req_class_label;
   logic signed [15:0]     req_rotation;
   logic                   req_end_of_set;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [15:0]            rsp_out_center_x;
   logic [15:0]            rsp_out_center_y;
   logic [15:0]            rsp_out_width;
   logic [15:0]            rsp_out_height;
   logic [15:0]            rsp_out_confidence;
   logic [7:0]             rsp_out_label;
   logic signed [15:0]     rsp_out_rotation;
   logic                   rsp_final_result;
   logic                   rsp_no_detections;
   logic                   rsp_capacity_overflow;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // shadow copy of the registers and of the ranked store
   logic [15:0]          thr_shadow  = SCORE_THRESHOLD_RESET;
   logic                 filt_shadow = CLASS_FILTER_EN_RESET;
   logic [63:0]          mask_shadow = CLASS_MASK_RESET;
   logic [MAX_DET_W-1:0] maxd_shadow = MAX_DETECTIONS_RESET;
   box_type              ranked_store [CAP];
   int                   kept = 0;
   bit                   store_overflowed = 0;

   result_type expected_boxes [$];

   int  errors        = 0;
   int  sent          = 0;
   int  boxes_checked = 0;
   int  sets_done     = 0;
   int  ovf_sets      = 0;
   int  full_cycles   = 0;
   int  rsp_hold_left = 0;
   bit  steady        = 0;

   detection_score_filter_top_k dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_center_x          (req_center_x),
      .req_center_y          (req_center_y),
      .req_box_width         (req_box_width),
      .req_box_height        (req_box_height),
      .req_confidence        (req_confidence),
      .req_class_label       (req_class_label),
      .req_rotation          (req_rotation),
      .req_end_of_set        (req_end_of_set),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_out_center_x      (rsp_out_center_x),
      .rsp_out_center_y      (rsp_out_center_y),
      .rsp_out_width         (rsp_out_width),
      .rsp_out_height        (rsp_out_height),
      .rsp_out_confidence    (rsp_out_confidence),
      .rsp_out_label         (rsp_out_label),
      .rsp_out_rotation      (rsp_out_rotation),
      .rsp_final_result      (rsp_final_result),
      .rsp_no_detections     (rsp_no_detections),
      .rsp_capacity_overflow (rsp_capacity_overflow),
      .csr_wr_en             (csr_wr_en),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout: block stopped moving transactions");
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int idle_draw();
      if (steady)
         return 0;
      return $urandom_range(0, 4);
   endfunction

   task automatic flag_error(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // filter, rank, and on the last proposal of a set queue the boxes it emits
   function automatic void rank_and_emit(proposal_type p);
      box_type    b;
      result_type r;
      int         pos;
      int         emit;
      bit         keep;
      keep = (p.conf >= thr_shadow);
      if (filt_shadow && (p.label > 8'd63 || !mask_shadow[p.label[5:0]]))
         keep = 1'b0;
      if (keep) begin
         b = '{score: p.conf, center_x: p.cx, center_y: p.cy, width: p.w, height: p.h,
               angle: p.rot, label: p.label};
         pos = 0;
         while (pos < kept && ranked_store[pos].score >= p.conf)
            pos++;
         if (kept >= CAP) begin
            // full store: the lowest entry falls out, ties keep the older box
            store_overflowed = 1'b1;
            if (pos < CAP) begin
               for (int i = CAP - 1; i > pos; i--)
                  ranked_store[i] = ranked_store[i - 1];
               ranked_store[pos] = b;
            end
         end else begin
            for (int i = kept; i > pos; i--)
               ranked_store[i] = ranked_store[i - 1];
            ranked_store[pos] = b;
            kept++;
         end
      end
      if (!p.eos)
         return;
      sets_done++;
      if (store_overflowed)
         ovf_sets++;
      if (kept == 0) begin
         r            = '0;
         r.final_flag = 1'b1;
         r.no_det     = 1'b1;
         r.ovf        = store_overflowed;
         expected_boxes = {expected_boxes, r};
      end else begin
         emit = kept;
         if (maxd_shadow != 0 && int'(maxd_shadow) < emit)
            emit = int'(maxd_shadow);
         for (int k = 0; k < emit; k++) begin
            r.box        = ranked_store[k];
            r.final_flag = (k == emit - 1);
            r.no_det     = 1'b0;
            r.ovf        = store_overflowed;
            expected_boxes = {expected_boxes, r};
         end
      end
      kept             = 0;
      store_overflowed = 1'b0;
   endfunction

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         flag_error($sformatf("box %0d field %s got %0h expected %0h",
                              boxes_checked, name, got, want));
   endtask

   task automatic compare_result(result_type want);
      check_field("center_x", rsp_out_center_x, want.box.center_x);
      check_field("center_y", rsp_out_center_y, want.box.center_y);
      check_field("width", rsp_out_width, want.box.width);
      check_field("height", rsp_out_height, want.box.height);
      check_field("confidence", rsp_out_confidence, want.box.score);
      check_field("label", {8'd0, rsp_out_label}, {8'd0, want.box.label});
      check_field("rotation", rsp_out_rotation, want.box.angle);
      check_field("final_result", {15'd0, rsp_final_result}, {15'd0, want.final_flag});
      check_field("no_detections", {15'd0, rsp_no_detections}, {15'd0, want.no_det});
      check_field("capacity_overflow", {15'd0, rsp_capacity_overflow}, {15'd0, want.ovf});
   endtask

   // result side: pop with random gaps, long hold when asked
   initial begin : result_checker
      int         wait_left;
      result_type want;
      wait_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (expected_boxes.size() == 0) begin
               flag_error("result transaction with nothing expected");
            end else begin
               want = expected_boxes.pop_front();
               compare_result(want);
            end
            boxes_checked++;
            wait_left = idle_draw();
         end
         if (rsp_hold_left > 0)
            rsp_hold_left--;
         rsp_pop <= (wait_left == 0 && rsp_hold_left == 0);
         if (wait_left > 0)
            wait_left--;
      end
   end

   task automatic program_csrs(logic [15:0] thr, logic en, logic [63:0] mask,
                               logic [MAX_DET_W-1:0] maxd);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_SCORE_THRESHOLD;
      csr_wdata <= {48'd0, thr};
      @(posedge clock);
      csr_index <= CSR_CLASS_FILTER_EN;
      csr_wdata <= {63'd0, en};
      @(posedge clock);
      csr_index <= CSR_CLASS_MASK;
      csr_wdata <= mask;
      @(posedge clock);
      csr_index <= CSR_MAX_DETECTIONS;
      csr_wdata <= {57'd0, maxd};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      thr_shadow  = thr;
      filt_shadow = en;
      mask_shadow = mask;
      maxd_shadow = maxd;
   endtask

   task automatic push_proposal(proposal_type p);
      int gap;
      req_push        <= 1'b1;
      req_center_x    <= p.cx;
      req_center_y    <= p.cy;
      req_box_width   <= p.w;
      req_box_height  <= p.h;
      req_confidence  <= p.conf;
      req_class_label <= p.label;
      req_rotation    <= p.rot;
      req_end_of_set  <= p.eos;
      @(posedge clock);
      while (req_full) begin
         full_cycles++;
         @(posedge clock);
      end
      rank_and_emit(p);
      sent++;
      // push stays high when the next transaction follows at once
      gap = idle_draw();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_push <= 1'b0;
      while (expected_boxes.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic proposal_type rand_proposal(logic [15:0] conf, logic [7:0] label,
                                                  logic eos);
      proposal_type p;
      p.cx    = 16'($urandom);
      p.cy    = 16'($urandom);
      p.w     = 16'($urandom);
      p.h     = 16'($urandom);
      p.conf  = conf;
      p.label = label;
      p.rot   = 16'($urandom);
      p.eos   = eos;
      return p;
   endfunction

   function automatic logic [15:0] pooled_score();
      case ($urandom_range(0, 2))
         0:       return 16'h4000;
         1:       return 16'h8000;
         default: return 16'hC000;
      endcase
   endfunction

   function automatic logic [15:0] random_score();
      int near;
      case ($urandom_range(0, 5))
         0: return 16'($urandom);
         1: begin
            near = int'(thr_shadow) + int'($urandom_range(0, 2)) - 1;
            if (near < 0)
               near = 0;
            if (near > 65535)
               near = 65535;
            return 16'(near);
         end
         2: return pooled_score();
         3: return 16'hFFFF;
         4: return 16'h0000;
         default: return 16'($urandom_range(int'(thr_shadow), 65535));
      endcase
   endfunction

   function automatic logic [7:0] random_label();
      if ($urandom_range(0, 9) < 7)
         return 8'($urandom_range(0, 63));
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic test_directed();
      program_csrs(16'd16384, 1'b0, 64'd0, 7'd0);
      // lone proposal below threshold: empty set
      push_proposal(rand_proposal(16'd16383, 8'd3, 1'b1));
      wait_for_drain();
      // exact threshold, field extremes, equal scores in arrival order
      push_proposal('{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd16384, 8'd0, 16'h8000, 1'b0});
      push_proposal('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'h7FFF, 1'b0});
      push_proposal(rand_proposal(16'd30000, 8'd7, 1'b0));
      push_proposal(rand_proposal(16'd30000, 8'd8, 1'b0));
      // last proposal ties the best kept box and is ranked behind it
      push_proposal(rand_proposal(16'hFFFF, 8'd1, 1'b1));
      wait_for_drain();
      // class mask allows labels 0 and 63 only, one box emitted
      program_csrs(16'd16384, 1'b1, 64'h8000_0000_0000_0001, 7'd1);
      push_proposal(rand_proposal(16'd20000, 8'd0, 1'b0));
      push_proposal(rand_proposal(16'd50000, 8'd63, 1'b0));
      push_proposal(rand_proposal(16'd60000, 8'd64, 1'b0));
      push_proposal(rand_proposal(16'hFFFF, 8'd255, 1'b0));
      push_proposal(rand_proposal(16'd40000, 8'd5, 1'b0));
      push_proposal(rand_proposal(16'd100, 8'd0, 1'b1));
      wait_for_drain();
      // zero threshold with all classes allowed, labels above 63 still blocked
      program_csrs(16'd0, 1'b1, {64{1'b1}}, 7'd64);
      push_proposal(rand_proposal(16'd0, 8'd63, 1'b0));
      push_proposal(rand_proposal(16'hFFFF, 8'd64, 1'b0));
      push_proposal(rand_proposal(16'd0, 8'd10, 1'b1));
      wait_for_drain();
      program_csrs(16'hFFFF, 1'b0, 64'd0, 7'd0);
      push_proposal(rand_proposal(16'hFFFE, 8'd2, 1'b0));
      push_proposal(rand_proposal(16'hFFFF, 8'd200, 1'b0));
      push_proposal(rand_proposal(16'd0, 8'd0, 1'b1));
      wait_for_drain();
   endtask

   task automatic test_overflow_backpressure();
      program_csrs(16'd1000, 1'b0, 64'd0, 7'd0);
      steady        = 1'b1;
      rsp_hold_left = 600;
      // more survivors than the store holds, few distinct scores for ties
      for (int i = 0; i < 80; i++)
         push_proposal(rand_proposal(pooled_score(), random_label(), i == 79));
      // next set comes in while results are held back, so the input stalls
      for (int i = 0; i < 20; i++)
         push_proposal(rand_proposal(random_score(), random_label(), i == 19));
      steady = 1'b0;
      wait_for_drain();
   endtask

   task automatic test_random();
      int budget;
      int len;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: program_csrs(16'd16384, 1'b0, 64'd0, 7'd0);
            1: program_csrs(16'd0, 1'b1, {64{1'b1}}, 7'd64);
            2: program_csrs(16'hFFFF, 1'b0, 64'd0, 7'd1);
            3: program_csrs(16'($urandom), 1'b1, {$urandom, $urandom},
                            7'($urandom_range(0, 64)));
            4: program_csrs(16'($urandom), 1'b1, 64'd0, 7'd0);
            5: program_csrs(16'($urandom), 1'b0, {$urandom, $urandom},
                            7'($urandom_range(0, 64)));
            default: program_csrs(16'h8000, 1'b1, {$urandom, $urandom}, 7'd5);
         endcase
         steady = (ph == 2 || ph == 5);
         budget = sent + 32;
         while (sent < budget) begin
            // mostly short frames, now and then a long one that can overflow the store
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
               push_proposal(rand_proposal(random_score(), random_label(), i == len - 1));
         end
         steady = 1'b0;
         wait_for_drain();
      end
   endtask

   initial begin
      reset           <= 1'b1;
      req_push        <= 1'b0;
      req_center_x    <= '0;
      req_center_y    <= '0;
      req_box_width   <= '0;
      req_box_height  <= '0;
      req_confidence  <= '0;
      req_class_label <= '0;
      req_rotation    <= '0;
      req_end_of_set  <= 1'b0;
      csr_wr_en       <= 1'b0;
      csr_index       <= '0;
      csr_wdata       <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow_backpressure();
      test_random();
      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("sent %0d proposals in %0d frames, %0d of them overflowing the store",
               sent, sets_done, ovf_sets);
      $display("checked %0d result boxes; input stalled by full for %0d cycles",
               boxes_checked, full_cycles);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== detection_score_filter_top_k.f =====
hdl/dsftk_pkg.sv
hdl/dsftk_queue.sv
hdl/dsftk_front.sv
hdl/dsftk_rank.sv
hdl/detection_score_filter_top_k.sv
hdl/dsftk_checker.sv
sim/tb_detection_score_filter_top_k.sv
